@@ hdl/kaf_pkg.sv @@
// kaf_pkg: shared types and constants of the two-state angle filter
// payload structs, micro-op encoding and the step table of the sequencer
// no dependencies
package kaf_pkg;

  // input sample and result payloads
  typedef struct packed {
    logic signed [31:0] measured_angle;
    logic signed [31:0] measured_rate;
    logic        [9:0]  loop_time_ms;
  } kaf_sample_t;

  typedef struct packed {
    logic signed [31:0] filtered_angle;
    logic signed [31:0] gyro_bias;
  } kaf_result_t;

  // configuration register indexes
  localparam logic [1:0] CFG_ANGLE_Q = 2'd0;
  localparam logic [1:0] CFG_BIAS_Q  = 2'd1;
  localparam logic [1:0] CFG_MEAS_R  = 2'd2;

  localparam logic [30:0] ANGLE_Q_RESET = 31'd66;
  localparam logic [30:0] BIAS_Q_RESET  = 31'd197;
  localparam logic [30:0] MEAS_R_RESET  = 31'd1966;

  // milliseconds per second, and half of it for rounding
  localparam int MS_PER_S = 1000;
  localparam int MS_HALF  = MS_PER_S / 2;

  localparam logic signed [31:0] SAT_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] SAT_MIN = 32'sh80000000;

  // operations of the shared datapath
  typedef enum logic [2:0] {
    OP_ADD,   // dst = a + b
    OP_SUB,   // dst = a - b
    OP_MAC,   // dst = c + a*b
    OP_MSC,   // dst = c - a*b
    OP_DIV,   // dst = a / b in fixed point
    OP_DT     // dst = loop time in seconds
  } op_t;

  // operand and destination selects
  typedef enum logic [4:0] {
    R_ANG, R_BIAS, R_PAA, R_PAB, R_PBA, R_PBB,
    R_DT, R_RATE, R_Y, R_S, R_K0, R_K1, R_T1, R_T2,
    R_MA, R_MR, R_QA, R_QB, R_RM, R_ZERO
  } sel_t;

  typedef struct packed {
    op_t  op;
    sel_t a;
    sel_t b;
    sel_t c;
    sel_t dst;
  } uop_t;

  localparam logic [4:0] LAST_STEP = 5'd19;

  // saturating 32-bit add or subtract
  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b,
                                                 input logic sub);
    logic signed [32:0] s;
    s = sub ? ({a[31], a} - {b[31], b}) : ({a[31], a} + {b[31], b});
    if (s[32] != s[31]) begin
      return s[32] ? SAT_MIN : SAT_MAX;
    end
    return s[31:0];
  endfunction

  // predict then update, covariance written in place
  function automatic uop_t step_rom(input logic [4:0] idx);
    uop_t u;
    case (idx)
      5'd0:  u = '{OP_DT,  R_ZERO, R_ZERO, R_ZERO, R_DT};
      5'd1:  u = '{OP_SUB, R_MR,   R_BIAS, R_ZERO, R_RATE};
      5'd2:  u = '{OP_MAC, R_DT,   R_RATE, R_ANG,  R_ANG};
      5'd3:  u = '{OP_ADD, R_PBA,  R_PAB,  R_ZERO, R_T1};
      5'd4:  u = '{OP_MAC, R_QA,   R_DT,   R_ZERO, R_T2};
      5'd5:  u = '{OP_MSC, R_DT,   R_T1,   R_T2,   R_T1};
      5'd6:  u = '{OP_ADD, R_PAA,  R_T1,   R_ZERO, R_PAA};
      5'd7:  u = '{OP_MSC, R_DT,   R_PBB,  R_PAB,  R_PAB};
      5'd8:  u = '{OP_MSC, R_DT,   R_PBB,  R_PBA,  R_PBA};
      5'd9:  u = '{OP_MAC, R_QB,   R_DT,   R_PBB,  R_PBB};
      5'd10: u = '{OP_SUB, R_MA,   R_ANG,  R_ZERO, R_Y};
      5'd11: u = '{OP_ADD, R_PAA,  R_RM,   R_ZERO, R_S};
      5'd12: u = '{OP_DIV, R_PAA,  R_S,    R_ZERO, R_K0};
      5'd13: u = '{OP_DIV, R_PBA,  R_S,    R_ZERO, R_K1};
      5'd14: u = '{OP_MAC, R_K0,   R_Y,    R_ANG,  R_ANG};
      5'd15: u = '{OP_MAC, R_K1,   R_Y,    R_BIAS, R_BIAS};
      5'd16: u = '{OP_MSC, R_K1,   R_PAA,  R_PBA,  R_PBA};
      5'd17: u = '{OP_MSC, R_K1,   R_PAB,  R_PBB,  R_PBB};
      5'd18: u = '{OP_MSC, R_K0,   R_PAA,  R_PAA,  R_PAA};
      5'd19: u = '{OP_MSC, R_K0,   R_PAB,  R_PAB,  R_PAB};
      default: u = '{OP_ADD, R_ZERO, R_ZERO, R_ZERO, R_T2};
    endcase
    return u;
  endfunction

endpackage

@@ hdl/kaf_stream_if.sv @@
// kaf_stream_if: valid/ready channel carrying one payload per transfer
// payload type given by parameter; no dependencies
interface kaf_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/kalman_angle_filter_top.sv @@
// kalman_angle_filter_top: two-state angle and gyro bias filter
// depends on kaf_pkg and kaf_stream_if
//
// Usage:
//   sample_in  carries measured_angle, measured_rate (Q format signed) and
//   loop_time_ms; result_out carries filtered_angle and gyro_bias, one result
//   per sample. Noise registers are written on cfg_we with cfg_index and
//   cfg_data; the user must write them only while the block is idle, and
//   the block itself does not enforce this. Index 3 is ignored.
//   One shared 32x32 multiplier, one saturating adder and one bit-serial
//   divider run a 20-step micro-program. Add steps write back in the fetch
//   state, multiply steps pass through the fetch, multiply and accumulate
//   states (loop time scaling is a reciprocal multiply), and divide steps
//   (the two gains) go from fetch to the divide state, where the divider
//   produces one quotient bit per cycle.
//   sample_in.ready is high only between samples; a new sample is taken
//   while the previous result still waits in the output register.
//   If the receiver stalls, the finished step holds until the output register
//   is free, then the result moves out.
//   Reset clears the estimates and covariance to zero and loads the default
//   noise settings.
module kalman_angle_filter_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  kaf_stream_if.sink   sample_in,
  kaf_stream_if.source result_out,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_data
);
  import kaf_pkg::*;

  localparam int NW    = 32 + FRAC_BITS;
  localparam int CNT_W = $clog2(NW + 1);
  localparam logic signed [63:0] RND   = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [63:0] MAX64 = 64'sh7fffffff;
  localparam logic signed [63:0] MIN64 = -64'sh80000000;

  // loop time scaling: 1000 = 8 * 125, the 8 folds into the shift and the
  // 125 is a multiply by ceil(2^37 / 125) then a 37-bit shift, exact below 2^31
  localparam logic signed [31:0] DT_RECIP = 32'sd1099511628;
  localparam int DT_SHIFT = 37;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_FETCH = 7'b0000010,
    S_MUL   = 7'b0000100,
    S_ACC   = 7'b0001000,
    S_DIV   = 7'b0010000,
    S_DONE  = 7'b0100000,
    S_OUTW  = 7'b1000000
  } state_t;

  state_t state;
  logic [4:0] pc;

  // configuration
  logic [30:0] qa, qb, rm;

  // sample and working registers
  logic signed [31:0] ma, mr;
  logic [9:0] ms;
  logic signed [31:0] ang, bias, paa, pab, pba, pbb;
  logic signed [31:0] dt, rate, y, s, k0, k1, t1, t2;

  // shared multiplier
  logic signed [63:0] prod;
  logic signed [31:0] mres;

  // divider
  logic [NW-1:0] num, quo;
  logic [31:0]   den;
  logic [31:0]   rem;
  logic          dneg, dzero;
  logic [CNT_W-1:0] dcnt;

  logic        out_valid;
  kaf_result_t out_data;

  uop_t u;
  logic signed [31:0] va, vb, vc, wval;
  logic signed [63:0] rnd_sh;
  logic signed [31:0] mul_sat;
  logic [32:0] trial;
  logic signed [31:0] div_res;
  logic [31:0] amag, bmag;
  logic        wen;
  logic signed [31:0] dt_num;

  function automatic logic signed [31:0] pick(
      input sel_t sel, input logic signed [31:0] r_ang, r_bias, r_paa, r_pab,
      r_pba, r_pbb, r_dt, r_rate, r_y, r_s, r_k0, r_k1, r_t1, r_t2, r_ma,
      r_mr, r_qa, r_qb, r_rm);
    logic signed [31:0] v;
    case (sel)
      R_ANG:  v = r_ang;
      R_BIAS: v = r_bias;
      R_PAA:  v = r_paa;
      R_PAB:  v = r_pab;
      R_PBA:  v = r_pba;
      R_PBB:  v = r_pbb;
      R_DT:   v = r_dt;
      R_RATE: v = r_rate;
      R_Y:    v = r_y;
      R_S:    v = r_s;
      R_K0:   v = r_k0;
      R_K1:   v = r_k1;
      R_T1:   v = r_t1;
      R_T2:   v = r_t2;
      R_MA:   v = r_ma;
      R_MR:   v = r_mr;
      R_QA:   v = r_qa;
      R_QB:   v = r_qb;
      R_RM:   v = r_rm;
      default: v = '0;
    endcase
    return v;
  endfunction

  // micro-op decode and operand selection
  always_comb begin
    u  = step_rom(pc);
    va = pick(u.a, ang, bias, paa, pab, pba, pbb, dt, rate, y, s, k0, k1, t1,
              t2, ma, mr, {1'b0, qa}, {1'b0, qb}, {1'b0, rm});
    vb = pick(u.b, ang, bias, paa, pab, pba, pbb, dt, rate, y, s, k0, k1, t1,
              t2, ma, mr, {1'b0, qa}, {1'b0, qb}, {1'b0, rm});
    vc = pick(u.c, ang, bias, paa, pab, pba, pbb, dt, rate, y, s, k0, k1, t1,
              t2, ma, mr, {1'b0, qa}, {1'b0, qb}, {1'b0, rm});
  end

  // loop time numerator already divided by 8, rounding half included
  always_comb begin
    dt_num = (32'(ms) << (FRAC_BITS - 3)) + 32'(MS_HALF >> 3);
  end

  // product rounding, half up, then saturation
  always_comb begin
    rnd_sh = (prod + RND) >>> FRAC_BITS;
    if (rnd_sh > MAX64) begin
      mul_sat = SAT_MAX;
    end else if (rnd_sh < MIN64) begin
      mul_sat = SAT_MIN;
    end else begin
      mul_sat = rnd_sh[31:0];
    end
  end

  // divider step and final sign and saturation
  always_comb begin
    trial = {rem, num[NW-1]};
    amag  = va[31] ? 32'(-va) : 32'(va);
    bmag  = vb[31] ? 32'(-vb) : 32'(vb);
    if (dzero) begin
      div_res = '0;
    end else if (dneg) begin
      if (quo > NW'(33'h080000000)) begin
        div_res = SAT_MIN;
      end else begin
        div_res = 32'(-quo);
      end
    end else if (quo > NW'(32'h7fffffff)) begin
      div_res = SAT_MAX;
    end else begin
      div_res = quo[31:0];
    end
  end

  // write-back value and enable
  always_comb begin
    wen  = 1'b0;
    wval = '0;
    unique case (state)
      S_FETCH: begin
        if (u.op == OP_ADD || u.op == OP_SUB) begin
          wen  = 1'b1;
          wval = sat_add(va, vb, u.op == OP_SUB);
        end
      end
      S_ACC: begin
        wen  = 1'b1;
        wval = sat_add(vc, mres, u.op == OP_MSC);
      end
      S_DIV: begin
        wen  = (dcnt == '0);
        wval = div_res;
      end
      default: begin
        wen  = 1'b0;
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      qa <= ANGLE_Q_RESET;
      qb <= BIAS_Q_RESET;
      rm <= MEAS_R_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ANGLE_Q: qa <= cfg_data;
        CFG_BIAS_Q:  qb <= cfg_data;
        CFG_MEAS_R:  rm <= cfg_data;
        default: ;
      endcase
    end
  end

  // state write-back
  always_ff @(posedge clk) begin
    if (rst) begin
      ang  <= '0;
      bias <= '0;
      paa  <= '0;
      pab  <= '0;
      pba  <= '0;
      pbb  <= '0;
    end else if (wen) begin
      case (u.dst)
        R_ANG:  ang  <= wval;
        R_BIAS: bias <= wval;
        R_PAA:  paa  <= wval;
        R_PAB:  pab  <= wval;
        R_PBA:  pba  <= wval;
        R_PBB:  pbb  <= wval;
        default: ;
      endcase
    end
  end

  // scratch registers, no reset
  always_ff @(posedge clk) begin
    if (wen) begin
      case (u.dst)
        R_DT:   dt   <= wval;
        R_RATE: rate <= wval;
        R_Y:    y    <= wval;
        R_S:    s    <= wval;
        R_K0:   k0   <= wval;
        R_K1:   k1   <= wval;
        R_T1:   t1   <= wval;
        R_T2:   t2   <= wval;
        default: ;
      endcase
    end
  end

  // sample capture, multiplier and divider datapath
  always_ff @(posedge clk) begin
    if (sample_in.valid && sample_in.ready) begin
      ma <= sample_in.data.measured_angle;
      mr <= sample_in.data.measured_rate;
      ms <= sample_in.data.loop_time_ms;
    end
    if (state == S_FETCH) begin
      prod  <= (u.op == OP_DT) ? dt_num * DT_RECIP : va * vb;
      rem   <= '0;
      quo   <= '0;
      num   <= {amag, {FRAC_BITS{1'b0}}};
      den   <= bmag;
      dneg  <= va[31] ^ vb[31];
      dzero <= (vb == '0);
    end
    if (state == S_MUL) begin
      mres <= (u.op == OP_DT) ? 32'(prod >>> DT_SHIFT) : mul_sat;
    end
    if (state == S_DIV && dcnt != '0) begin
      num <= num << 1;
      if (trial >= {1'b0, den}) begin
        rem <= 32'(trial - {1'b0, den});
        quo <= {quo[NW-2:0], 1'b1};
      end else begin
        rem <= trial[31:0];
        quo <= {quo[NW-2:0], 1'b0};
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pc    <= '0;
      dcnt  <= '0;
    end else begin
      unique case (state) inside
        S_IDLE: begin
          pc <= '0;
          if (sample_in.valid) begin
            state <= S_FETCH;
          end
        end
        S_FETCH: begin
          case (u.op) inside
            OP_MAC, OP_MSC, OP_DT: state <= S_MUL;
            OP_DIV: begin
              state <= S_DIV;
              dcnt  <= CNT_W'(NW);
            end
            default: begin
              if (pc == LAST_STEP) begin
                state <= S_DONE;
              end else begin
                pc <= pc + 5'd1;
              end
            end
          endcase
        end
        S_MUL: begin
          state <= S_ACC;
        end
        S_ACC, S_DIV: begin
          if (state == S_DIV && dcnt != '0) begin
            dcnt <= dcnt - CNT_W'(1);
          end else if (pc == LAST_STEP) begin
            state <= S_DONE;
          end else begin
            pc    <= pc + 5'd1;
            state <= S_FETCH;
          end
        end
        S_DONE: begin
          if (!out_valid || result_out.ready) begin
            state <= S_IDLE;
          end else begin
            state <= S_OUTW;
          end
        end
        S_OUTW: begin
          if (!out_valid || result_out.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_DONE || state == S_OUTW) &&
                 (!out_valid || result_out.ready)) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE || state == S_OUTW) && (!out_valid || result_out.ready)) begin
      out_data.filtered_angle <= ang;
      out_data.gyro_bias      <= bias;
    end
  end

  assign sample_in.ready  = (state == S_IDLE);
  assign result_out.valid = out_valid;
  assign result_out.data  = out_data;

  // checks on the sequencer
  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_start: assert property (@(posedge clk) disable iff (rst)
    sample_in.valid && sample_in.ready |=> state == S_FETCH && pc == '0)
    else $error("sample transfer did not start the program");
  a_pc: assert property (@(posedge clk) disable iff (rst) pc <= LAST_STEP)
    else $error("step counter past last step");
  a_div: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV && dcnt != '0 |=> state == S_DIV)
    else $error("divider left early");
  a_result: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && !out_valid |=> out_valid && state == S_IDLE)
    else $error("result not loaded");

endmodule
